@@ hw/rtl/mppr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mppr_pkg;

  // Port count and the width of one port's interrupt block
  localparam int NUM_PORTS   = 4;
  localparam int PORT_W      = 2;
  localparam int BLOCK_W     = 4;
  localparam int REQ_W       = NUM_PORTS * BLOCK_W;

  // Field widths
  localparam int DATA_W      = 32;
  localparam int OFS_W       = 8;
  localparam int CNUM_W      = 2;
  localparam int SIZE_W      = 3;
  localparam int START_W     = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int S_TDATA_W   = 48;
  localparam int M_TDATA_W   = 40;

  // Register constants
  localparam logic [DATA_W-1:0] CTL_WRITABLE = 32'h0000_0073;
  localparam logic [DATA_W-1:0] PORT_CODE    = 32'h0000_0040;
  localparam int                MASTER_EN_BIT = 0;

  // Register offsets
  localparam logic [OFS_W-1:0] REG_PORT  = 8'd0;
  localparam logic [OFS_W-1:0] REG_CTL   = 8'd1;
  localparam logic [OFS_W-1:0] REG_INVAL = 8'd3;
  localparam logic [OFS_W-1:0] REG_MAINT = 8'd7;
  localparam logic [OFS_W-1:0] REG_REQ   = 8'd8;
  localparam logic [OFS_W-1:0] REG_ENA   = 8'd9;
  localparam logic [OFS_W-1:0] REG_LAST  = 8'd9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_PORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_NUM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_CODE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ADDR = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_CODE_RESET = 3'd3;

  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_REMOTE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOREG  = 2'd1,
    ST_BADACC = 2'd2
  } status_t;

  // One request as taken from the input side
  typedef struct packed {
    logic [1:0]         func;
    logic [OFS_W-1:0]   reg_offset;
    logic [1:0]         byte_offset;
    logic               is_longword;
    logic [DATA_W-1:0]  write_data;
    logic [BLOCK_W-1:0] remote_ports;
  } req_t;

  // One result
  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    status_t            status;
    logic [BLOCK_W-1:0] send_ports;
    logic               raise_interrupt;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/mppr_in_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mppr_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mppr_pkg::req_t in_req,
  input  wire logic          take,
  output logic               req_valid,
  output mppr_pkg::req_t     req
);

  // Accept when empty or when the held request moves on this cycle
  assign in_ready = !req_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  // Hold payload until replaced
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req <= in_req;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mppr_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mppr_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [mppr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mppr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              take,
  input  wire mppr_pkg::req_t                    req,
  output mppr_pkg::res_t                         res
);

  logic [mppr_pkg::PORT_W-1:0]  local_port;
  logic [mppr_pkg::CNUM_W-1:0]  controller_number;
  logic [mppr_pkg::SIZE_W-1:0]  array_size_code;
  logic [mppr_pkg::START_W-1:0] start_address_field;

  logic [mppr_pkg::DATA_W-1:0]  interface_control;
  logic [mppr_pkg::REQ_W-1:0]   interrupt_requests;
  logic [mppr_pkg::DATA_W-1:0]  interrupt_enables;

  logic [mppr_pkg::DATA_W-1:0]  interface_control_next;
  logic [mppr_pkg::REQ_W-1:0]   interrupt_requests_next;
  logic [mppr_pkg::DATA_W-1:0]  interrupt_enables_next;

  logic [mppr_pkg::REQ_W-1:0]   block_shift;
  logic [mppr_pkg::REQ_W-1:0]   send_window;
  logic                         access;
  logic                         good;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_port          <= '0;
      controller_number   <= '0;
      array_size_code     <= mppr_pkg::SIZE_CODE_RESET;
      start_address_field <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mppr_pkg::CFG_LOCAL_PORT: local_port <= cfg_data[mppr_pkg::PORT_W-1:0];
        mppr_pkg::CFG_CTRL_NUM:   controller_number <= cfg_data[mppr_pkg::CNUM_W-1:0];
        mppr_pkg::CFG_SIZE_CODE:  array_size_code <= cfg_data[mppr_pkg::SIZE_W-1:0];
        mppr_pkg::CFG_START_ADDR: start_address_field <= cfg_data[mppr_pkg::START_W-1:0];
        default: ;
      endcase
    end
  end

  // Block position of this port inside the request word and the send field of the write data
  assign block_shift = mppr_pkg::REQ_W'({local_port, 2'b00});
  assign send_window = req.write_data[mppr_pkg::DATA_W-1:mppr_pkg::REQ_W] >> block_shift;
  assign access      = (req.func == mppr_pkg::FUNC_READ) || (req.func == mppr_pkg::FUNC_WRITE);
  assign good        = (req.byte_offset == 2'b00) && req.is_longword
                       && (req.reg_offset <= mppr_pkg::REG_LAST);

  // Decode the request into a result and the next state
  always_comb begin
    interface_control_next  = interface_control;
    interrupt_requests_next = interrupt_requests;
    interrupt_enables_next  = interrupt_enables;
    res.read_data           = '0;
    res.status              = mppr_pkg::ST_OK;
    res.send_ports          = '0;

    if (access) begin
      if ((req.byte_offset != 2'b00) || !req.is_longword) begin
        res.status = mppr_pkg::ST_BADACC;
      end else if (req.reg_offset > mppr_pkg::REG_LAST) begin
        res.status = mppr_pkg::ST_NOREG;
      end else if (req.func == mppr_pkg::FUNC_READ) begin
        case (req.reg_offset)
          mppr_pkg::REG_PORT:  res.read_data = mppr_pkg::PORT_CODE
                                 | mppr_pkg::DATA_W'(local_port);
          mppr_pkg::REG_CTL:   res.read_data = interface_control;
          mppr_pkg::REG_INVAL: res.read_data = {start_address_field, 1'b0,
                                 array_size_code, 16'h0000};
          mppr_pkg::REG_MAINT: res.read_data = mppr_pkg::DATA_W'({controller_number,
                                 14'h0000});
          mppr_pkg::REG_REQ:   res.read_data = mppr_pkg::DATA_W'(interrupt_requests);
          mppr_pkg::REG_ENA:   res.read_data = interrupt_enables;
          default:             res.read_data = '0;
        endcase
      end else begin
        case (req.reg_offset)
          mppr_pkg::REG_CTL:   interface_control_next =
                                 (interface_control & ~mppr_pkg::CTL_WRITABLE)
                                 | (req.write_data & mppr_pkg::CTL_WRITABLE);
          mppr_pkg::REG_REQ:   res.send_ports = send_window[mppr_pkg::BLOCK_W-1:0];
          mppr_pkg::REG_ENA:   interrupt_enables_next = req.write_data;
          default: ;
        endcase
      end
    end else if (req.func == mppr_pkg::FUNC_REMOTE) begin
      interrupt_requests_next = interrupt_requests
        | (mppr_pkg::REQ_W'(req.remote_ports) << block_shift);
    end

    // Level after this request
    res.raise_interrupt =
      (|(interrupt_requests_next & interrupt_enables_next[mppr_pkg::DATA_W-1:mppr_pkg::REQ_W]))
      && interface_control_next[mppr_pkg::MASTER_EN_BIT];
  end

  // Commit state when the request moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      interface_control  <= '0;
      interrupt_requests <= '0;
      interrupt_enables  <= '0;
    end else if (take) begin
      interface_control  <= interface_control_next;
      interrupt_requests <= interrupt_requests_next;
      interrupt_enables  <= interrupt_enables_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Request bits are only cleared by reset
  a_req_sticky: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((interrupt_requests & $past(interrupt_requests)) == $past(interrupt_requests)))
    else $error("interrupt request bit cleared");

  // Read-only control bits stay zero
  a_ctl_ro: assert property (@(posedge clk) disable iff (rst)
    (interface_control & ~mppr_pkg::CTL_WRITABLE) == '0)
    else $error("read-only control bit set");

  // Send requests only come from a good write to the request register
  a_send_src: assert property (@(posedge clk) disable iff (rst)
    (take && (res.send_ports != '0)) |-> (req.func == mppr_pkg::FUNC_WRITE
      && req.reg_offset == mppr_pkg::REG_REQ && res.status == mppr_pkg::ST_OK))
    else $error("send ports from wrong request");

  // A rejected access changes no state
  a_bad_hold: assert property (@(posedge clk) disable iff (rst)
    (take && res.status != mppr_pkg::ST_OK) |=> ($stable(interface_control)
      && $stable(interrupt_requests) && $stable(interrupt_enables)))
    else $error("rejected access changed state");

  // Good accesses never report an error
  a_good_ok: assert property (@(posedge clk) disable iff (rst)
    (access && good) |-> res.status == mppr_pkg::ST_OK)
    else $error("good access flagged");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/mppr_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mppr_out_stage (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  wire mppr_pkg::res_t res_in,
  output logic             take,
  output logic             out_valid,
  input  wire logic        out_ready,
  output mppr_pkg::res_t   res
);

  logic free;

  // Load a new result when empty or when the held one leaves
  assign free = !out_valid || out_ready;
  assign take = req_valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_in;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/multiport_memory_port_registers_unit.sv @@
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser func; tdata offset, alignment, data, remote ports
// m_*       out  m_tvalid/m_tready  tuser status; tdata read data, send ports, interrupt
// cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// One request per cycle sustained while m_tready stays high; a request is held in the input
// register, then its result in the result register.
// The result register frees the input register when it is empty or m_tready is high.
// Reset (rst, synchronous) clears valid flags, port state and configuration.
// A stall on m_tready holds the result and backs up into s_tready.
`timescale 1ns / 1ps
`default_nettype none

module multiport_memory_port_registers_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // [7:0] reg_offset, [9:8] byte_offset, [10] is_longword, [42:11] write_data,
  // [46:43] remote_ports, [47] zero
  input  wire logic [mppr_pkg::S_TDATA_W-1:0]      s_tdata,
  // [1:0] func
  input  wire logic [1:0]                          s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [31:0] read_data, [35:32] send_ports, [36] raise_interrupt, [39:37] zero
  output logic [mppr_pkg::M_TDATA_W-1:0]           m_tdata,
  // [1:0] status
  output logic [1:0]                               m_tuser,
  input  wire logic                                cfg_we,
  input  wire logic [mppr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mppr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mppr_pkg::req_t in_req;
  mppr_pkg::req_t req;
  mppr_pkg::res_t res_next;
  mppr_pkg::res_t res;
  logic           req_valid;
  logic           take;

  // Unpack the input request
  assign in_req.func         = s_tuser;
  assign in_req.reg_offset   = s_tdata[7:0];
  assign in_req.byte_offset  = s_tdata[9:8];
  assign in_req.is_longword  = s_tdata[10];
  assign in_req.write_data   = s_tdata[42:11];
  assign in_req.remote_ports = s_tdata[46:43];

  mppr_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (in_req),
    .take      (take),
    .req_valid (req_valid),
    .req       (req)
  );

  mppr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .req       (req),
    .res       (res_next)
  );

  mppr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .res_in    (res_next),
    .take      (take),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  // Pack the result
  assign m_tdata = {3'b000, res.raise_interrupt, res.send_ports, res.read_data};
  assign m_tuser = res.status;

endmodule

`default_nettype wire

@@ verif/port_regs_checker.sv @@
`timescale 1ns / 1ps

// Watches the request, reply and register-write channels of the port register
// block, keeps its own copy of the port state and predicts every reply.
module port_regs_checker
  import mppr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  input  wire logic                   s_tready,
  input  wire logic [S_TDATA_W-1:0]   s_tdata,
  input  wire logic [1:0]             s_tuser,
  input  wire logic                   m_tvalid,
  input  wire logic                   m_tready,
  input  wire logic [M_TDATA_W-1:0]   m_tdata,
  input  wire logic [1:0]             m_tuser,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output int                          mismatches,
  output int                          outstanding,
  output int                          replies_checked
);

  // Port setup as last written
  logic [PORT_W-1:0]  cur_port;
  logic [CNUM_W-1:0]  cur_ctrl;
  logic [SIZE_W-1:0]  cur_size;
  logic [START_W-1:0] cur_start;

  // Port state
  logic [DATA_W-1:0]  ctl_reg;
  logic [REQ_W-1:0]   req_bits;
  logic [DATA_W-1:0]  ena_reg;

  res_t pending_replies[$];
  int   bad_count = 0;
  int   good_count = 0;

  assign mismatches      = bad_count;
  assign replies_checked = good_count;

  // Apply one request to the port state and return the reply it should give
  function automatic res_t service_request(logic [1:0] fn, logic [OFS_W-1:0] ofs,
                                           logic [1:0] bofs, logic lw,
                                           logic [DATA_W-1:0] wdata,
                                           logic [BLOCK_W-1:0] remote);
    res_t        r;
    int unsigned base;
    base     = cur_port * BLOCK_W;
    r        = '0;
    r.status = ST_OK;
    if (fn == FUNC_READ || fn == FUNC_WRITE) begin
      if (bofs != 2'd0 || !lw) begin
        r.status = ST_BADACC;
      end else if (ofs > REG_LAST) begin
        r.status = ST_NOREG;
      end else if (fn == FUNC_READ) begin
        case (ofs)
          REG_PORT:  r.read_data = PORT_CODE | DATA_W'(cur_port);
          REG_CTL:   r.read_data = ctl_reg;
          REG_INVAL: r.read_data = {cur_start, 1'b0, cur_size, 16'h0000};
          REG_MAINT: r.read_data = {16'h0000, cur_ctrl, 14'h0000};
          REG_REQ:   r.read_data = DATA_W'(req_bits);
          REG_ENA:   r.read_data = ena_reg;
          default:   r.read_data = '0;
        endcase
      end else begin
        case (ofs)
          REG_CTL: ctl_reg = (ctl_reg & ~CTL_WRITABLE) | (wdata & CTL_WRITABLE);
          // Send to the ports named in this port's block; requests stay as they are
          REG_REQ: r.send_ports = wdata[16 + base +: BLOCK_W];
          REG_ENA: ena_reg = wdata;
          default: ;
        endcase
      end
    end else if (fn == FUNC_REMOTE) begin
      req_bits = req_bits | (REQ_W'(remote) << base);
    end
    r.raise_interrupt = ((req_bits & ena_reg[DATA_W-1:16]) != '0) && ctl_reg[MASTER_EN_BIT];
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      cur_port  = '0;
      cur_ctrl  = '0;
      cur_size  = SIZE_CODE_RESET;
      cur_start = '0;
      ctl_reg   = '0;
      req_bits  = '0;
      ena_reg   = '0;
      pending_replies.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOCAL_PORT: cur_port  = cfg_data[PORT_W-1:0];
          CFG_CTRL_NUM:   cur_ctrl  = cfg_data[CNUM_W-1:0];
          CFG_SIZE_CODE:  cur_size  = cfg_data[SIZE_W-1:0];
          CFG_START_ADDR: cur_start = cfg_data[START_W-1:0];
          default: ;
        endcase
      end

      // Predict the reply of each accepted request
      if (s_tvalid && s_tready) begin
        pending_replies.push_back(service_request(s_tuser, s_tdata[7:0], s_tdata[9:8],
                                                  s_tdata[10], s_tdata[42:11],
                                                  s_tdata[46:43]));
      end

      // Compare each accepted reply with the oldest prediction
      if (m_tvalid && m_tready) begin
        if (pending_replies.size() == 0) begin
          if (bad_count < 10)
            $display("[%0t] reply with no request pending: data %h status %0d",
                     $time, m_tdata[31:0], m_tuser);
          bad_count++;
        end else begin
          want = pending_replies.pop_front();
          if (m_tdata[31:0] !== want.read_data || m_tuser !== want.status ||
              m_tdata[35:32] !== want.send_ports || m_tdata[36] !== want.raise_interrupt) begin
            if (bad_count < 10) begin
              $display("[%0t] reply mismatch: expected data %h status %0d send %h irq %b",
                       $time, want.read_data, want.status, want.send_ports,
                       want.raise_interrupt);
              $display("                     got      data %h status %0d send %h irq %b",
                       m_tdata[31:0], m_tuser, m_tdata[35:32], m_tdata[36]);
            end
            bad_count++;
          end else begin
            good_count++;
          end
        end
      end
    end
    outstanding <= pending_replies.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import mppr_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 180;
  localparam int TIMEOUT_NS   = 5_000_000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  logic [1:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic [1:0]             m_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatches;
  int outstanding;
  int replies_checked;

  // Shared pacing controls
  bit steady = 1'b0;
  bit hold_request = 1'b0;
  int requests_sent = 0;
  int settings_used = 1;
  int sender_pauses = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  multiport_memory_port_registers_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  port_regs_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .replies_checked (replies_checked)
  );

  // Offer one request, after a random gap unless steady, and hold it until taken
  task automatic offer(input logic [1:0] fn, input logic [OFS_W-1:0] ofs,
                       input logic [1:0] bofs, input logic lw,
                       input logic [DATA_W-1:0] wdata, input logic [BLOCK_W-1:0] remote);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {1'b0, remote, wdata, lw, bofs, ofs};
    do @(posedge clk); while (!s_tready);
    requests_sent++;
  endtask

  // Stop offering until every reply is back, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sender_pauses++;
  endtask

  // Write all four setup registers on consecutive cycles; block must be idle
  task automatic load_setup(input logic [PORT_W-1:0] port, input logic [CNUM_W-1:0] ctrl,
                            input logic [SIZE_W-1:0] size, input logic [START_W-1:0] start);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOCAL_PORT;
    cfg_data  <= CFG_DATA_W'(port);
    @(posedge clk);
    cfg_index <= CFG_CTRL_NUM;
    cfg_data  <= CFG_DATA_W'(ctrl);
    @(posedge clk);
    cfg_index <= CFG_SIZE_CODE;
    cfg_data  <= CFG_DATA_W'(size);
    @(posedge clk);
    cfg_index <= CFG_START_ADDR;
    cfg_data  <= start;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // Mostly well-formed longword accesses, some bad ones, remote arrivals, unused code
  task automatic random_request();
    int                 pick;
    logic [1:0]         fn;
    logic [OFS_W-1:0]   ofs;
    logic [1:0]         bofs;
    logic               lw;
    logic [DATA_W-1:0]  wdata;
    pick  = $urandom_range(0, 99);
    fn    = (pick < 40) ? FUNC_READ : (pick < 75) ? FUNC_WRITE :
            (pick < 95) ? FUNC_REMOTE : FUNC_UNUSED;
    ofs   = OFS_W'($urandom_range(0, 9));
    bofs  = 2'd0;
    lw    = 1'b1;
    wdata = $urandom;
    pick  = $urandom_range(0, 99);
    if (pick < 8) begin
      ofs = OFS_W'($urandom_range(10, 255));
    end else if (pick < 20) begin
      ofs  = OFS_W'($urandom);
      bofs = 2'($urandom);
      lw   = 1'($urandom);
    end
    // Sparse enables so the request/enable match goes both ways
    if (fn == FUNC_WRITE && ofs == REG_ENA) begin
      case ($urandom_range(0, 2))
        1: wdata[31:16] = 16'h0000;
        2: wdata[31:16] = 16'h0001 << $urandom_range(0, 15);
        default: ;
      endcase
    end
    offer(fn, ofs, bofs, lw, wdata, BLOCK_W'($urandom));
  endtask

  // Reply side: random stalls, one long hold on request
  initial begin
    int stall;
    wait (!rst);
    forever begin
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 4);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Request side and verdict
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every register at reset setup
    for (int r = REG_PORT; r <= REG_LAST; r++)
      offer(FUNC_READ, OFS_W'(r), 2'd0, 1'b1, 32'h0, 4'h0);
    // Control keeps only its writable bits
    offer(FUNC_WRITE, REG_CTL, 2'd0, 1'b1, 32'hFFFF_FFFF, 4'h0);
    offer(FUNC_READ, REG_CTL, 2'd0, 1'b1, 32'h0, 4'h0);
    offer(FUNC_WRITE, REG_ENA, 2'd0, 1'b1, 32'hFFFF_0000, 4'h0);
    // Remote arrival with junk in the ignored fields raises the interrupt
    offer(FUNC_REMOTE, 8'hFF, 2'd3, 1'b0, 32'hFFFF_FFFF, 4'hF);
    offer(FUNC_READ, REG_REQ, 2'd0, 1'b1, 32'h0, 4'h0);
    // Sending does not clear requests
    offer(FUNC_WRITE, REG_REQ, 2'd0, 1'b1, 32'hFFFF_FFFF, 4'h0);
    offer(FUNC_READ, REG_REQ, 2'd0, 1'b1, 32'h0, 4'h0);
    // Master enable off, then on
    offer(FUNC_WRITE, REG_CTL, 2'd0, 1'b1, 32'h0, 4'h0);
    offer(FUNC_WRITE, REG_CTL, 2'd0, 1'b1, 32'h1, 4'h0);
    // Missing registers
    offer(FUNC_READ, 8'd10, 2'd0, 1'b1, 32'h0, 4'h0);
    offer(FUNC_WRITE, 8'hFF, 2'd0, 1'b1, 32'hFFFF_FFFF, 4'h0);
    // Bad alignment, bad length
    offer(FUNC_READ, REG_PORT, 2'd3, 1'b1, 32'h0, 4'h0);
    offer(FUNC_WRITE, REG_ENA, 2'd0, 1'b0, 32'h0, 4'h0);
    // Write to a read-only register is dropped
    offer(FUNC_WRITE, REG_PORT, 2'd0, 1'b1, 32'hFFFF_FFFF, 4'h0);
    // Unused function code
    offer(FUNC_UNUSED, REG_CTL, 2'd0, 1'b1, 32'h0, 4'hF);
    drain();

    // Random phases over several setups, extremes first
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: load_setup(2'd3, 2'd3, 3'd7, 12'hFFF);
        1: load_setup(2'd0, 2'd0, 3'd0, 12'h000);
        default: load_setup(PORT_W'(phase % NUM_PORTS), CNUM_W'($urandom),
                            SIZE_W'($urandom), START_W'($urandom));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 60 == 0)
          steady = ($urandom_range(0, 3) == 0);
        if (phase == 2 && n == 90)
          hold_request = 1'b1;
        random_request();
        if (phase == 4 && n == 90)
          drain();
      end
      drain();
    end

    steady = 1'b0;
    repeat (8) @(posedge clk);
    $display("Sent %0d requests under %0d port setups; %0d replies checked.",
             requests_sent, settings_used, replies_checked);
    $display("Covered bad accesses, missing registers, remote arrivals, %0d sender pauses.",
             sender_pauses);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
